### design/multichannel_percent_pwm_generator_core_assert.svh
// Assertion macros shared by the PWM core modules.
`ifndef MULTICHANNEL_PERCENT_PWM_GENERATOR_CORE_ASSERT_SVH
`define MULTICHANNEL_PERCENT_PWM_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTH
// Plain property, checked on every clock edge out of reset.
`define MPPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication.
`define MPPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define MPPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPPG_ASSERT(lbl, prop, msg)
`define MPPG_ASSERT_IMP(lbl, ante, cons, msg)
`define MPPG_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### design/mppg_pkg.sv
package mppg_pkg;

  localparam int CHANNELS = 21;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int LEVEL_W   = 21;
  localparam int CHAN_W    = 5;
  localparam int DUTY_IN_W = 8;
  localparam int DUTY_W    = 7;
  localparam int CNT_W     = 16;
  localparam int CMP_W     = 17;
  localparam int PROD_W    = 23;
  localparam int CFG_IDX_W = 2;

  localparam logic [DUTY_W-1:0] DUTY_MAX     = 7'd100;
  localparam logic [CNT_W-1:0]  PRESCALE_RST = 16'd83;
  localparam logic [CNT_W-1:0]  PERIOD_RST   = 16'd4999;

  // floor(p / 100) = (p * RECIP_M) >> RECIP_SHIFT for every p below 2**23
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 24;
  localparam int RECIP_PW    = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M = 24'd10737419;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd1;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_READ = 2'd2,
    OP_STOP = 2'd3
  } opcode_e;

  typedef struct packed {
    logic latch;
    logic mul;
    logic div;
    logic exec;
    logic resp;
  } ctrl_cmd_t;

endpackage

### design/mppg_ctrl.sv
module mppg_ctrl
  import mppg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [1:0]  opcode_i,
  output logic        busy,
  output ctrl_cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  // the response cycle also takes the next word
  assign busy   = !((state_q == S_IDLE) || (state_q == S_RESP));
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE, S_RESP: begin
        if (start) begin
          state_d = (opcode_i == OP_SET) ? S_MUL : S_EXEC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MUL:   state_d = S_DIV;
      S_DIV:   state_d = S_EXEC;
      S_EXEC:  state_d = S_RESP;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.latch = accept;
  assign cmd_o.mul   = (state_q == S_MUL);
  assign cmd_o.div   = (state_q == S_DIV);
  assign cmd_o.exec  = (state_q == S_EXEC);
  assign cmd_o.resp  = (state_q == S_RESP);

`include "multichannel_percent_pwm_generator_core_assert.svh"

  `MPPG_ASSERT_IMP(a_resp_after_exec, state_q == S_RESP, $past(state_q) == S_EXEC, "resp without exec")
  `MPPG_ASSERT_NXT(a_div_to_exec, state_q == S_DIV, state_q == S_EXEC, "div not followed by exec")
  `MPPG_ASSERT_IMP(a_mul_only_set, state_q == S_MUL, $past(accept && (opcode_i == OP_SET)), "mul without set")

endmodule

### design/mppg_dp.sv
module mppg_dp
  import mppg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  input  logic [1:0]            opcode_i,
  input  logic [CHAN_W-1:0]     channel_i,
  input  logic [DUTY_IN_W-1:0]  duty_percent_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CNT_W-1:0]      cfg_data_i,
  output logic [LEVEL_W-1:0]    pwm_levels_o,
  output logic [DUTY_W-1:0]     read_duty_o,
  output logic                  update_event_o
);

  logic [CNT_W-1:0]  prescale_q, period_q;
  logic [CNT_W-1:0]  presc_cnt_q, cnt_q;

  opcode_e           op_q;
  logic [CHAN_W-1:0] ch_q;
  logic [DUTY_W-1:0] duty_q;

  logic [PROD_W-1:0] prod_q;
  logic [CMP_W-1:0]  quot_q;
  logic [RECIP_PW-1:0] recip_full;

  logic [DUTY_W-1:0] duty_store_q [CHANNELS];
  logic [CMP_W-1:0]  preload_q    [CHANNELS];
  logic [CMP_W-1:0]  active_q     [CHANNELS];

  logic [DUTY_W-1:0] rd_q;
  logic              upd_q;

  logic                ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [CMP_W-1:0]    period_p1;

  assign ch_ok     = (ch_q < CHAN_W'(CHANNELS));
  assign ch_idx    = ch_q[CH_IDX_W-1:0];
  assign period_p1 = {1'b0, period_q} + CMP_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= PRESCALE_RST;
      period_q   <= PERIOD_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_PRESCALE) begin
        prescale_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_PERIOD) begin
        period_q <= cfg_data_i;
      end
    end
  end

  // command capture, clamp applied on the way in
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= opcode_e'(opcode_i);
      ch_q   <= channel_i;
      duty_q <= (duty_percent_i > DUTY_IN_W'(DUTY_MAX)) ? DUTY_MAX
                                                        : duty_percent_i[DUTY_W-1:0];
    end
  end

  // compare = (period+1)*duty/100 in two multiplier steps
  assign recip_full = RECIP_PW'(prod_q) * RECIP_PW'(RECIP_M);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(period_p1) * PROD_W'(duty_q);
    end
    if (cmd_i.div) begin
      quot_q <= recip_full[RECIP_SHIFT+CMP_W-1:RECIP_SHIFT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_cnt_q <= '0;
      cnt_q       <= '0;
      rd_q        <= '0;
      upd_q       <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        duty_store_q[c] <= '0;
        preload_q[c]    <= '0;
        active_q[c]     <= '0;
      end
    end else if (cmd_i.exec) begin
      rd_q  <= '0;
      upd_q <= 1'b0;
      case (op_q)
        OP_TICK: begin
          if (presc_cnt_q >= prescale_q) begin
            presc_cnt_q <= '0;
            if (cnt_q >= period_q) begin
              cnt_q <= '0;
              upd_q <= 1'b1;
              for (int c = 0; c < CHANNELS; c++) begin
                active_q[c] <= preload_q[c];
              end
            end else begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
          end else begin
            presc_cnt_q <= presc_cnt_q + CNT_W'(1);
          end
        end
        OP_SET: begin
          if (ch_ok) begin
            duty_store_q[ch_idx] <= duty_q;
            preload_q[ch_idx]    <= quot_q;
          end
        end
        OP_READ: begin
          if (ch_ok) begin
            rd_q <= duty_store_q[ch_idx];
          end
        end
        OP_STOP: begin
          for (int c = 0; c < CHANNELS; c++) begin
            duty_store_q[c] <= '0;
            preload_q[c]    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    pwm_levels_o = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      pwm_levels_o[c] = ({1'b0, cnt_q} < active_q[c]);
    end
  end

  assign read_duty_o    = rd_q;
  assign update_event_o = upd_q;

`include "multichannel_percent_pwm_generator_core_assert.svh"

  `MPPG_ASSERT_IMP(a_upd_cnt_zero, upd_q, cnt_q == '0, "update with counter not at zero")
  `MPPG_ASSERT(a_rd_in_range, rd_q <= DUTY_MAX, "read duty above maximum")
  `MPPG_ASSERT_NXT(a_presc_hold, !cmd_i.exec, $stable(presc_cnt_q), "prescaler moved outside exec")

endmodule

### design/multichannel_percent_pwm_generator_core.sv
// Channel  | Handshake                     | Payload
// ---------+-------------------------------+----------------------------------------
// command  | start / busy                  | opcode_i, channel_i, duty_percent_i
// result   | out_valid_o (one-cycle strobe) | pwm_levels_o, read_duty_o, update_event_o
// config   | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// Tick, read and stop words: the word passes the exec state, then the response
// state with the result strobe; a new word is taken in the strobe cycle.
// Set duty: multiply, divide, exec and response states; the multiply and divide
// states run the compare and reciprocal multipliers for the divide by 100.
// Reset clears counters, duties and compares at once; no clearing pass.
// The result side cannot stall: each result is shown for exactly one cycle.
module multichannel_percent_pwm_generator_core
  import mppg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command word
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            opcode_i,
  input  logic [CHAN_W-1:0]     channel_i,
  input  logic [DUTY_IN_W-1:0]  duty_percent_i,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CNT_W-1:0]      cfg_data_i,
  // result word
  output logic                  out_valid_o,
  output logic [LEVEL_W-1:0]    pwm_levels_o,
  output logic [DUTY_W-1:0]     read_duty_o,
  output logic                  update_event_o
);

  ctrl_cmd_t cmd;

  // the user must write registers only while idle; the block itself does not enforce it, so the port is always open
  assign cfg_ready_o = 1'b1;

  mppg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  // datapath: counters, duty and compare banks, divide-by-100 multipliers
  mppg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (opcode_i),
    .channel_i      (channel_i),
    .duty_percent_i (duty_percent_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pwm_levels_o   (pwm_levels_o),
    .read_duty_o    (read_duty_o),
    .update_event_o (update_event_o)
  );

  // result strobe in the cycle after the word has been applied
  assign out_valid_o = cmd.resp;

endmodule
